/* hdl/line_fold_at_blank_unit_assert.svh */
// assertion macros used by the checker file
`ifndef LINE_FOLD_AT_BLANK_UNIT_ASSERT_SVH
`define LINE_FOLD_AT_BLANK_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LFAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lfab assertion failed");

// next-cycle implication, disabled while reset is low
`define LFAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lfab assertion failed");

`endif

/* hdl/lfab_pkg.sv */
package lfab_pkg;

    localparam int CHAR_W = 8;
    localparam int CFG_W  = 6;

    localparam logic [CHAR_W-1:0] BLANK   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE = 8'h0A;

    localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd50;
    localparam logic [CFG_W-1:0] MIN_WIDTH   = 6'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_COPY
    } t_state;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              is_end;
    } t_in_beat;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last_of_run;
    } t_out_beat;

    // output stage control from the sequencer
    typedef struct packed {
        logic valid;
        logic sel_nl;
    } t_out_ctl;

endpackage

/* hdl/lfab_ram.sv */
module lfab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, data holds while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lfab_seq.sv */
module lfab_seq import lfab_pkg::*; #(
    parameter int MAX_WIDTH = 63,
    localparam int AW       = $clog2(MAX_WIDTH),
    localparam int CW       = $clog2(MAX_WIDTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_beat          i_in_data,
    output logic              o_in_stall,
    input  logic              i_out_stall,
    input  logic [CW-1:0]     i_width,
    output t_out_ctl          o_out_ctl,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [CHAR_W-1:0] o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  logic [CHAR_W-1:0] i_rdata
);

    t_state r_state, n_state;

    // line bookkeeping
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_nb_len, n_nb_len;
    logic          r_lb_valid, n_lb_valid;
    logic [AW-1:0] r_lb_pos, n_lb_pos;
    logic [CW-1:0] r_lb_len, n_lb_len;
    logic          r_skip, n_skip;

    // run and copy sequencing
    logic [CW-1:0]     r_len, n_len;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic              r_fold, n_fold;
    logic [AW-1:0]     r_src, n_src;
    logic [AW-1:0]     r_dst, n_dst;
    logic [CW-1:0]     r_left, n_left;
    logic              r_wr_pend, n_wr_pend;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_out_valid, n_out_valid;
    logic              r_sel_nl, n_sel_nl;

    logic              acc;
    logic              adv;
    logic              full;
    logic              is_blank;
    logic              is_nl;
    logic [CHAR_W-1:0] c;
    logic              d_emit;
    logic              d_append;
    logic              d_fold;
    logic [CW-1:0]     d_len;
    logic [CW-1:0]     d_left;
    logic [AW-1:0]     d_src;

    assign acc      = i_in_valid && (r_state == ST_IDLE);
    assign adv      = !r_out_valid || !i_out_stall;
    assign c        = i_in_data.char_in;
    assign is_blank = (c == BLANK);
    assign is_nl    = (c == NEWLINE);
    assign full     = (r_count >= i_width);

    // per-beat decision and bookkeeping update
    always_comb begin
        d_emit     = 1'b0;
        d_append   = 1'b0;
        d_fold     = 1'b0;
        d_len      = '0;
        d_left     = '0;
        d_src      = '0;
        n_count    = r_count;
        n_nb_len   = r_nb_len;
        n_lb_valid = r_lb_valid;
        n_lb_pos   = r_lb_pos;
        n_lb_len   = r_lb_len;
        n_skip     = r_skip;
        if (acc) begin
            if (i_in_data.is_end || is_nl) begin
                // flush what is held; a newline always gives a run
                d_emit     = !i_in_data.is_end || (r_count != '0);
                d_len      = r_count;
                n_count    = '0;
                n_nb_len   = '0;
                n_lb_valid = 1'b0;
                n_skip     = 1'b0;
            end else if (!(is_blank && r_skip)) begin
                n_skip = 1'b0;
                if (!full) begin
                    d_append = 1'b1;
                    n_count  = r_count + CW'(1);
                    if (is_blank) begin
                        n_lb_valid = 1'b1;
                        n_lb_pos   = r_count[AW-1:0];
                        n_lb_len   = r_nb_len;
                    end else begin
                        n_nb_len = r_count + CW'(1);
                    end
                end else if (is_blank) begin
                    // break at the incoming blank, skip blanks after it
                    d_emit     = 1'b1;
                    d_len      = r_nb_len;
                    n_count    = '0;
                    n_nb_len   = '0;
                    n_lb_valid = 1'b0;
                    n_skip     = 1'b1;
                end else if (r_lb_valid) begin
                    // break at the last held blank, keep the tail
                    d_emit     = 1'b1;
                    d_fold     = 1'b1;
                    d_len      = r_lb_len;
                    d_src      = r_lb_pos + AW'(1);
                    d_left     = r_count - CW'(r_lb_pos) - CW'(1);
                    n_count    = d_left + CW'(1);
                    n_nb_len   = d_left + CW'(1);
                    n_lb_valid = 1'b0;
                end else begin
                    // hard break at the width
                    d_emit     = 1'b1;
                    d_fold     = 1'b1;
                    d_len      = r_count;
                    n_count    = CW'(1);
                    n_nb_len   = CW'(1);
                    n_lb_valid = 1'b0;
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (d_emit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (adv && (r_ptr == r_len)) begin
                    n_state = r_fold ? ST_COPY : ST_IDLE;
                end
            end
            ST_COPY: begin
                if ((r_left == '0) && !r_wr_pend) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory access and output stage
    always_comb begin
        o_we        = 1'b0;
        o_waddr     = '0;
        o_wdata     = '0;
        o_re        = 1'b0;
        o_raddr     = '0;
        n_len       = r_len;
        n_ptr       = r_ptr;
        n_fold      = r_fold;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_wr_pend   = 1'b0;
        n_char      = r_char;
        n_out_valid = r_out_valid;
        n_sel_nl    = r_sel_nl;
        unique case (r_state)
            ST_IDLE: begin
                if (adv) begin
                    n_out_valid = 1'b0;
                end
                if (d_append) begin
                    o_we    = 1'b1;
                    o_waddr = r_count[AW-1:0];
                    o_wdata = c;
                end
                if (d_emit) begin
                    n_len  = d_len;
                    n_ptr  = '0;
                    n_fold = d_fold;
                    n_src  = d_src;
                    n_left = d_left;
                    n_dst  = '0;
                    n_char = c;
                end
            end
            ST_EMIT: begin
                // the read register doubles as the output data register
                if (adv) begin
                    n_out_valid = 1'b1;
                    if (r_ptr != r_len) begin
                        o_re     = 1'b1;
                        o_raddr  = r_ptr[AW-1:0];
                        n_sel_nl = 1'b0;
                        n_ptr    = r_ptr + CW'(1);
                    end else begin
                        n_sel_nl = 1'b1;
                    end
                end
            end
            ST_COPY: begin
                if (adv) begin
                    n_out_valid = 1'b0;
                end
                // move the kept tail to the front, then place the new char
                if (r_left != '0) begin
                    o_re      = 1'b1;
                    o_raddr   = r_src;
                    n_src     = r_src + AW'(1);
                    n_left    = r_left - CW'(1);
                    n_wr_pend = 1'b1;
                end
                if (r_wr_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_dst;
                    o_wdata = i_rdata;
                    n_dst   = r_dst + AW'(1);
                end else if (r_left == '0) begin
                    o_we    = 1'b1;
                    o_waddr = r_dst;
                    o_wdata = r_char;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_nb_len    <= '0;
            r_lb_valid  <= 1'b0;
            r_skip      <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_sel_nl    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_nb_len    <= n_nb_len;
            r_lb_valid  <= n_lb_valid;
            r_skip      <= n_skip;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
            r_sel_nl    <= n_sel_nl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lb_pos <= n_lb_pos;
        r_lb_len <= n_lb_len;
        r_len    <= n_len;
        r_ptr    <= n_ptr;
        r_fold   <= n_fold;
        r_src    <= n_src;
        r_dst    <= n_dst;
        r_left   <= n_left;
        r_char   <= n_char;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_ctl.valid  = r_out_valid;
    assign o_out_ctl.sel_nl = r_sel_nl;

endmodule

/* hdl/line_fold_at_blank_unit.sv */
// Greedy word-wrap line folder for a byte stream. Text bytes are held in a
// line store of MAX_WIDTH bytes; a byte that only joins the line is written
// to the store without stalling the input. A byte that completes a line
// (newline, end of input, or a fold) moves the folder to an emit state that
// sends the held bytes and then a closing newline, all gated by output
// backpressure; a break at a held blank or at the width then moves the kept
// tail to the front of the store and places the new byte (only the byte
// when no tail is kept). The line store has a single read port, one byte
// per cycle. Input stall is high while a line is emitted or moved.
// The wrap width register takes writes at any time (ready is always high);
// values below 2 act as 2 and values above MAX_WIDTH act as MAX_WIDTH.
module line_fold_at_blank_unit import lfab_pkg::*; #(
    parameter int MAX_WIDTH = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_beat         i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_beat        o_out_data,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam logic [CFG_W:0] MAX_W_CMP = (CFG_W + 1)'(MAX_WIDTH);

    logic [CFG_W-1:0]  r_wrap_width;
    logic [CW-1:0]     width_eff;
    t_out_ctl          out_ctl;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [CHAR_W-1:0] mem_rdata;

    // wrap width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_width <= WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wrap_width <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamp the width into the supported range
    always_comb begin
        if ({1'b0, r_wrap_width} > MAX_W_CMP) begin
            width_eff = CW'(MAX_WIDTH);
        end else if (r_wrap_width < MIN_WIDTH) begin
            width_eff = CW'(MIN_WIDTH);
        end else begin
            width_eff = CW'(r_wrap_width);
        end
    end

    lfab_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .i_width     (width_eff),
        .o_out_ctl   (out_ctl),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    lfab_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output beat: held byte from the store or the closing newline
    assign o_out_valid            = out_ctl.valid;
    assign o_out_data.char_out    = out_ctl.sel_nl ? NEWLINE : mem_rdata;
    assign o_out_data.last_of_run = out_ctl.sel_nl;

endmodule

/* hdl/lfab_checker.sv */
`include "line_fold_at_blank_unit_assert.svh"

module lfab_checker import lfab_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input t_in_beat         i_in_data,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input t_out_beat        o_out_data,
    input logic             i_out_stall
);

    logic in_nl_beat;

    assign in_nl_beat = i_in_valid && !o_in_stall && !i_in_data.is_end
                        && (i_in_data.char_in == NEWLINE);

    // a stalled output beat holds
    `LFAB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // the beat that closes a run is a newline
    `LFAB_ASSERT_NOW(a_last_is_nl, i_clk, i_rst_n, o_out_valid && o_out_data.last_of_run, o_out_data.char_out == NEWLINE)

    // a newline beat always starts a run, so input stalls right after it
    `LFAB_ASSERT_NEXT(a_nl_stalls, i_clk, i_rst_n, in_nl_beat, o_in_stall)

    // a new output beat only appears while a run is in progress
    `LFAB_ASSERT_NOW(a_out_in_run, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind line_fold_at_blank_unit lfab_checker u_lfab_checker (.*);

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import lfab_pkg::*;

    localparam int MAX_W = 63;
    localparam int NO_BLANK = 127;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;

    // expected output stream of the folder, kept as a line store mirror
    class fold_tracker;
        logic [CHAR_W-1:0] line_buf [MAX_W];
        int unsigned line_len;
        int unsigned blank_at;
        bit skipping;
        logic [CFG_W-1:0] width_reg;
        t_out_beat folded_q[$];
        int unsigned n_errors;

        function new();
            foreach (line_buf[k]) line_buf[k] = '0;
            width_reg = WIDTH_RESET;
            n_errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_len = 0;
            blank_at = NO_BLANK;
            skipping = 1'b0;
        endfunction

        function void set_width(logic [CFG_W-1:0] v);
            width_reg = v;
        endfunction

        function int unsigned pending();
            return folded_q.size();
        endfunction

        // queue the first n held bytes and a closing newline
        function void push_line(int unsigned n);
            t_out_beat ob;
            for (int k = 0; k < n && k < MAX_W; k++) begin
                ob.char_out = line_buf[k];
                ob.last_of_run = 1'b0;
                folded_q.push_back(ob);
            end
            ob.char_out = NEWLINE;
            ob.last_of_run = 1'b1;
            folded_q.push_back(ob);
        endfunction

        // fold one accepted input beat; returns 0 if the beat was skipped
        function bit note_char(t_in_beat b);
            int unsigned w;
            int unsigned n;
            int unsigned p;
            int unsigned rest;
            w = 32'(width_reg);
            if (w < 32'(MIN_WIDTH)) w = 32'(MIN_WIDTH);
            if (w > MAX_W) w = MAX_W;

            // end of input flushes whatever is held
            if (b.is_end) begin
                if (line_len > 0) push_line(line_len);
                clear_line();
                return 1'b1;
            end
            if (b.char_in == NEWLINE) begin
                push_line(line_len);
                clear_line();
                return 1'b1;
            end
            // blanks after a blank break are dropped
            if (b.char_in == BLANK && skipping) return 1'b0;
            skipping = 1'b0;

            // room left on the line
            if (line_len < w) begin
                if (b.char_in == BLANK) blank_at = line_len;
                line_buf[line_len] = b.char_in;
                line_len++;
                return 1'b1;
            end

            // incoming blank is the break point
            if (b.char_in == BLANK) begin
                n = line_len;
                while (n > 0 && line_buf[n-1] == BLANK) n--;
                push_line(n);
                clear_line();
                skipping = 1'b1;
                return 1'b1;
            end

            // break at the last held blank, keep the tail
            if (blank_at != NO_BLANK && blank_at < line_len) begin
                p = blank_at;
                n = p;
                while (n > 0 && line_buf[n-1] == BLANK) n--;
                push_line(n);
                rest = line_len - p - 1;
                for (int k = 0; k < rest; k++) line_buf[k] = line_buf[p+1+k];
                line_buf[rest] = b.char_in;
                line_len = rest + 1;
                blank_at = NO_BLANK;
                return 1'b1;
            end

            // no blank held: hard break at the width
            push_line(line_len);
            line_buf[0] = b.char_in;
            line_len = 1;
            blank_at = NO_BLANK;
            return 1'b1;
        endfunction

        // compare one accepted output beat with the oldest expectation
        function void check_char(t_out_beat got);
            t_out_beat want;
            if (folded_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected beat, expected none, actual char_out %h last_of_run %b",
                         $time, got.char_out, got.last_of_run);
                return;
            end
            want = folded_q.pop_front();
            if (got.char_out !== want.char_out) begin
                n_errors++;
                $display("%0t: char_out expected %h actual %h",
                         $time, want.char_out, got.char_out);
            end
            if (got.last_of_run !== want.last_of_run) begin
                n_errors++;
                $display("%0t: last_of_run expected %b actual %b",
                         $time, want.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    t_in_beat         i_in_data;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_beat        o_out_data;
    logic             i_out_stall;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;

    fold_tracker tracker = new();
    bit steady = 1'b0;
    int unsigned hold_req = 0;
    int unsigned cycle_count = 0;

    line_fold_at_blank_unit #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data(i_in_data),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data(o_out_data),
        .i_out_stall(i_out_stall),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: errors");
        $finish;
    end

    // output side stall: random, steady, or a long hold-off on request
    initial begin : receiver
        int unsigned hold_left;
        int unsigned holds_seen;
        hold_left = 0;
        holds_seen = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_seen != hold_req) begin
                holds_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (steady) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 36);
            end
        end
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) tracker.check_char(o_out_data);
    end

    // offer one beat after a random gap, return at the accepting edge
    task automatic send_beat(input t_in_beat b, output bit taken);
        while (!steady && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        do @(posedge i_clk); while (o_in_stall);
        taken = tracker.note_char(b);
    endtask

    task automatic send_text(input string s);
        t_in_beat b;
        bit taken;
        for (int k = 0; k < s.len(); k++) begin
            b.is_end = 1'b0;
            b.char_in = s[k];
            send_beat(b, taken);
        end
    endtask

    task automatic send_end();
        t_in_beat b;
        bit taken;
        b.is_end = 1'b1;
        b.char_in = CHAR_W'($urandom_range(0, 255));
        send_beat(b, taken);
    endtask

    // sender holds off until every expected beat has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_width(input logic [CFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.set_width(v);
    endtask

    // mostly words and blanks, some newlines, ends and raw bytes
    function automatic t_in_beat rand_beat(int unsigned w, int unsigned blank_pct);
        t_in_beat b;
        int unsigned roll;
        roll = $urandom_range(0, 999);
        b.is_end = 1'b0;
        b.char_in = CHAR_W'(8'h61 + $urandom_range(0, 25));
        if (roll < 8) begin
            b.is_end = 1'b1;
            b.char_in = CHAR_W'($urandom_range(0, 255));
        end else if (roll < 80) begin
            b.char_in = CHAR_W'($urandom_range(0, 255));
        end else if ($urandom_range(0, 2 * w) == 0) begin
            b.char_in = NEWLINE;
        end else if ($urandom_range(0, 99) < blank_pct) begin
            b.char_in = BLANK;
        end
        return b;
    endfunction

    task automatic run_random(input int unsigned w, input int unsigned n_items,
                              input bit with_hold, input bit with_pause);
        t_in_beat b;
        bit taken;
        int unsigned n_taken;
        int unsigned blank_pct;
        n_taken = 0;
        blank_pct = ($urandom_range(0, 2) == 0) ? 3 : 18;
        while (n_taken < n_items) begin
            if (with_hold && n_taken == n_items / 3) hold_req++;
            if (with_pause && n_taken == (2 * n_items) / 3) wait_drained();
            b = rand_beat(w, blank_pct);
            send_beat(b, taken);
            n_taken += taken;
        end
    endtask

    initial begin : main
        int unsigned v;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset width, then end with nothing held
        send_text("a b\n");
        send_end();

        // narrow line: blank fold, blank-run break with skip, hard break,
        // trailing blank before newline, empty prefix after blank removal
        write_width(6'd4);
        send_text("\nab cd    xyzwq \n abcd");

        // width lowered with text held, below-minimum value
        write_width(6'd1);
        run_random(2, 60, 1'b0, 1'b1);

        // widest line, no idling on either side
        write_width(6'd63);
        steady = 1'b1;
        run_random(63, 60, 1'b0, 1'b0);
        steady = 1'b0;

        // zero width with a long output hold-off
        write_width(6'd0);
        run_random(2, 60, 1'b1, 1'b0);

        v = $urandom_range(3, 62);
        write_width(v[CFG_W-1:0]);
        run_random(v, 60, 1'b0, 1'b0);

        write_width(6'd2);
        run_random(2, 50, 1'b0, 1'b0);

        v = $urandom_range(3, 62);
        write_width(v[CFG_W-1:0]);
        run_random(v, 60, 1'b1, 1'b1);

        send_end();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.n_errors == 0 && tracker.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/lfab_pkg.sv
hdl/lfab_ram.sv
hdl/lfab_seq.sv
hdl/line_fold_at_blank_unit.sv
hdl/lfab_checker.sv
tb/sv/tb_top.sv
